### design/fixed_block_pool_allocator_assert.svh
// Assertion macros used by the checker file.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FBPA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fbpa assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FBPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fbpa assertion failed");

`endif

### design/fbpa_pkg.sv
package fbpa_pkg;

   // Block size in bytes; a power of two so the block index is a shift.
   localparam int BLOCK_BYTES = 32;
   localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);

   localparam int ADDR_W = 16;
   localparam int ALLOC_ADDR_W = 13;
   localparam int CFG_W = 9;

   // Pool size after reset, before any register write.
   localparam int RESET_BLOCKS = 256;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

endpackage

### design/fbpa_link_ram.sv
module fbpa_link_ram #(
   parameter int DEPTH  = 256,
   parameter int AW     = 8,
   parameter int DW     = 10
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/fixed_block_pool_allocator.sv
// Channel  | Ports                                   | Direction
// ---------+-----------------------------------------+----------
// request  | req_valid req_stall req_type            | in
//          | req_block_addr                          |
// response | rsp_valid rsp_stall rsp_ok              | out
//          | rsp_alloc_addr                          |
// csr      | csr_wr_en csr_wr_data                   | in
//
// Each item first reads the link memory entry of the head block (alloc) or of the
// named block (free) in the idle state, then checks it and writes back in lookup.
// A completed item waits in the response register; an item stalled there
// holds the lookup stage, and the request side stalls until the lookup ends.
// Reset and a num_blocks write restart the pool at once: blocks at and above
// a fill count are implicitly free and chained in order, so no clearing pass.
module fixed_block_pool_allocator import fbpa_pkg::*; #(
   parameter int NUM_BLOCKS = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_type,
   input  logic [ADDR_W-1:0]       req_block_addr,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_ok,
   output logic [ALLOC_ADDR_W-1:0] rsp_alloc_addr,
   input  logic                    csr_wr_en,
   input  logic [CFG_W-1:0]        csr_wr_data
);

   localparam int LINK_W = $clog2(NUM_BLOCKS + 1);
   localparam int IDX_W = $clog2(NUM_BLOCKS);
   localparam int WORD_W = LINK_W + 1;
   localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_BLOCKS);
   localparam int RESET_ACTIVE = (RESET_BLOCKS < NUM_BLOCKS) ? RESET_BLOCKS : NUM_BLOCKS;

   state_type state_ff, state_in;

   logic [LINK_W-1:0] active_ff, active_in;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [LINK_W-1:0] fresh_ff, fresh_in;

   logic              op_ff, op_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              cand_ff, cand_in;
   logic              is_fresh_ff, is_fresh_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic [ALLOC_ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   logic              req_accept;
   logic              out_free;
   logic              lookup_done;
   logic [ADDR_W-1:0] req_blk;
   logic              req_aligned;
   logic [LINK_W-1:0] csr_active;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [WORD_W-1:0] rd_word;
   logic              wr_en;
   logic [WORD_W-1:0] wr_word;

   // Link memory: {in_use, next_link} per block
   fbpa_link_ram #(
      .DEPTH (NUM_BLOCKS),
      .AW    (IDX_W),
      .DW    (WORD_W)
   ) u_link_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_word)
   );

   // Decode the request
   assign req_accept  = req_valid && !req_stall;
   assign req_blk     = req_block_addr >> BLK_SHIFT;
   assign req_aligned = (req_block_addr[BLK_SHIFT-1:0] == '0);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign csr_active  = (32'(csr_wr_data) > NUM_BLOCKS) ? LINK_NONE : LINK_W'(csr_wr_data);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_stall   = 1'b1;
      lookup_done = 1'b0;
      case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_LOOKUP: lookup_done = out_free;
         default:   req_stall = 1'b1;
      endcase
   end

   // Capture the item and launch the memory read
   always_comb begin
      op_in       = op_ff;
      idx_in      = idx_ff;
      cand_in     = cand_ff;
      is_fresh_in = is_fresh_ff;
      rd_en       = req_accept;
      rd_addr     = head_ff[IDX_W-1:0];
      if (req_type == REQ_FREE) begin
         rd_addr = req_blk[IDX_W-1:0];
      end
      if (req_accept) begin
         op_in  = req_type;
         idx_in = rd_addr;
         if (req_type == REQ_FREE) begin
            // only blocks below the fill count can have been allocated
            cand_in     = req_aligned && (32'(req_blk) < 32'(fresh_ff));
            is_fresh_in = 1'b0;
         end else begin
            cand_in     = (head_ff < active_ff);
            is_fresh_in = (head_ff == fresh_ff);
         end
      end
   end

   // Check, update the list and write back
   always_comb begin
      active_in    = active_ff;
      head_in      = head_ff;
      fresh_in     = fresh_ff;
      wr_en        = 1'b0;
      wr_word      = rd_word;
      rsp_ok_in    = rsp_ok_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (lookup_done) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = 1'b0;
         rsp_addr_in  = '0;
         if (op_ff == REQ_ALLOC) begin
            if (cand_ff) begin
               rsp_ok_in   = 1'b1;
               rsp_addr_in = ALLOC_ADDR_W'(32'(idx_ff) << BLK_SHIFT);
               wr_en       = 1'b1;
               wr_word     = {1'b1, rd_word[LINK_W-1:0]};
               if (is_fresh_ff) begin
                  // untouched block: its link is the next index or none
                  fresh_in = fresh_ff + LINK_W'(1);
                  head_in  = (32'(fresh_ff) + 32'd1 < 32'(active_ff)) ?
                             fresh_ff + LINK_W'(1) : LINK_NONE;
               end else begin
                  head_in = rd_word[LINK_W-1:0];
               end
            end
         end else begin
            if (cand_ff && rd_word[LINK_W]) begin
               rsp_ok_in = 1'b1;
               wr_en     = 1'b1;
               wr_word   = {1'b0, head_ff};
               head_in   = LINK_W'(idx_ff);
            end
         end
      end
      // Rebuild the pool on a register write
      if (csr_wr_en) begin
         active_in = csr_active;
         fresh_in  = '0;
         head_in   = (csr_active != '0) ? '0 : LINK_NONE;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= LINK_W'(RESET_ACTIVE);
         head_ff      <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         head_ff      <= head_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      cand_ff     <= cand_in;
      is_fresh_ff <= is_fresh_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_addr_ff <= rsp_addr_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_alloc_addr = rsp_addr_ff;

endmodule

### design/fbpa_checker.sv
`include "fixed_block_pool_allocator_assert.svh"

module fbpa_checker import fbpa_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic                    rsp_ok,
   input logic [ALLOC_ADDR_W-1:0] rsp_alloc_addr
);

   logic [ALLOC_ADDR_W:0] rsp_data;

   assign rsp_data = {rsp_ok, rsp_alloc_addr};

   // Hold a stalled response
   `FBPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // A failed item reports a zero offset
   `FBPA_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && !rsp_ok, rsp_alloc_addr == '0)

   // Offsets are block aligned
   `FBPA_ASSERT_NOW(a_aligned, clock, reset, rsp_valid, rsp_alloc_addr[BLK_SHIFT-1:0] == '0)

   // One item at a time: stall after every accepted item
   `FBPA_ASSERT_NEXT(a_busy, clock, reset, req_valid && !req_stall, req_stall)

   // A new response follows a lookup cycle
   `FBPA_ASSERT_NOW(a_rsp_cause, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);

### dv/tb.sv
`timescale 1ns / 100ps

import fbpa_pkg::*;

localparam int TB_BLOCKS = 256;
localparam int LINK_W = 9;
localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(TB_BLOCKS);
localparam int REPORT_LIMIT = 10;

typedef struct packed {
   logic                    ok;
   logic [ALLOC_ADDR_W-1:0] addr;
} pool_rsp_type;

// Shadow of the free list; predicts one response per accepted request.
class pool_scoreboard;
   logic [LINK_W-1:0] link_mem [TB_BLOCKS];
   bit                in_use [TB_BLOCKS];
   logic [LINK_W-1:0] head;
   int                active;
   pool_rsp_type      pending [$];
   int                mismatches;

   // Clamp the block count and chain every block in order, all free.
   function void rebuild(logic [CFG_W-1:0] value);
      active = (value > TB_BLOCKS) ? TB_BLOCKS : int'(value);
      for (int i = 0; i < TB_BLOCKS; i++) begin
         link_mem[i] = (i + 1 < active) ? LINK_W'(i + 1) : LINK_NONE;
         in_use[i] = 1'b0;
      end
      head = (active > 0) ? '0 : LINK_NONE;
   endfunction

   // Pop or push the head and queue the expected response.
   function void note_request(req_op_type op, logic [ADDR_W-1:0] addr);
      pool_rsp_type rsp;
      int blk;
      rsp = '0;
      if (op == REQ_ALLOC) begin
         if (int'(head) < active) begin
            blk = int'(head);
            head = link_mem[blk];
            in_use[blk] = 1'b1;
            rsp.ok = 1'b1;
            rsp.addr = ALLOC_ADDR_W'(blk * BLOCK_BYTES);
         end
      end else begin
         blk = int'(addr) / BLOCK_BYTES;
         if ((int'(addr) % BLOCK_BYTES) == 0 && blk < active && in_use[blk]) begin
            link_mem[blk] = head;
            head = LINK_W'(blk);
            in_use[blk] = 1'b0;
            rsp.ok = 1'b1;
         end
      end
      pending.push_back(rsp);
   endfunction

   // Compare a response with the oldest expectation.
   function void check_response(logic ok, logic [ALLOC_ADDR_W-1:0] addr);
      pool_rsp_type want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("response with no request pending: ok=%0b alloc_addr=%0d", ok, addr);
         return;
      end
      want = pending.pop_front();
      if (want.ok !== ok || want.addr !== addr) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("mismatch: expected ok=%0b alloc_addr=%0d, got ok=%0b alloc_addr=%0d",
                     want.ok, want.addr, ok, addr);
      end
   endfunction

   // Random currently allocated block, or -1 when none is held.
   function int pick_allocated();
      int held [$];
      for (int i = 0; i < active; i++) begin
         if (in_use[i]) held.push_back(i);
      end
      if (held.size() == 0) return -1;
      return held[$urandom_range(held.size() - 1)];
   endfunction
endclass

module tb;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int CSR_PAUSE = 4;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_type = 1'b0;
   logic [ADDR_W-1:0]       req_block_addr = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_ok;
   logic [ALLOC_ADDR_W-1:0] rsp_alloc_addr;
   logic                    csr_wr_en = 1'b0;
   logic [CFG_W-1:0]        csr_wr_data = '0;

   pool_scoreboard sb = new();

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   logic want_hold_off = 1'b0;
   logic hold_off_used = 1'b0;
   int hold_off_count = 0;
   int quiet_cycles = 0;
   int pool_sizes [8] = '{4, 1, 256, 0, 511, 16, 2, 100};

   fixed_block_pool_allocator dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_block_addr (req_block_addr),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ok         (rsp_ok),
      .rsp_alloc_addr (rsp_alloc_addr),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Drain responses; stall at random or for one long hold-off.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_ok, rsp_alloc_addr);
         if (want_hold_off && !hold_off_used) begin
            hold_off_used <= 1'b1;
            hold_off_count <= HOLD_OFF_CYCLES;
            rsp_stall <= 1'b1;
         end else if (hold_off_count != 0) begin
            hold_off_count <= hold_off_count - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // End the run when nothing moves for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no item moved in %0d cycles", QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Offer one request after an optional gap; hold it until accepted.
   task automatic send_request(input req_op_type op, input logic [ADDR_W-1:0] addr);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_block_addr <= addr;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note_request(op, addr);
   endtask

   // Let the pool go idle, then write the block count.
   task automatic set_pool_size(input logic [CFG_W-1:0] value);
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending.size() != 0);
      repeat (CSR_PAUSE) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.rebuild(value);
   endtask

   // Mostly legal alloc/free traffic, with some broken frees mixed in.
   task automatic run_random(input int count);
      int pick;
      int blk;
      logic [ADDR_W-1:0] addr;
      req_op_type op;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         addr = ADDR_W'($urandom);
         op = REQ_FREE;
         if (pick < 45) begin
            op = REQ_ALLOC;
         end else if (pick < 85) begin
            blk = sb.pick_allocated();
            if (blk < 0) op = REQ_ALLOC;
            else addr = ADDR_W'(blk * BLOCK_BYTES);
         end else if (pick < 90) begin
            // misaligned offset
            addr[BLK_SHIFT-1:0] = BLK_SHIFT'($urandom_range(BLOCK_BYTES - 1, 1));
         end else if (pick < 95) begin
            // aligned but past the pool
            addr = ADDR_W'($urandom_range(2047, sb.active) * BLOCK_BYTES);
         end else if (pick < 98 && sb.active > 0) begin
            // aligned in range, usually a block that is already free
            addr = ADDR_W'($urandom_range(sb.active - 1) * BLOCK_BYTES);
         end
         send_request(op, addr);
      end
   endtask

   initial begin
      int count;
      sb.rebuild(CFG_W'(RESET_BLOCKS));
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset pool: LIFO order, each kind of bad free, ignored alloc address.
      send_request(REQ_ALLOC, 16'h0000);
      send_request(REQ_ALLOC, 16'h0000);
      send_request(REQ_FREE, 16'h0001);
      send_request(REQ_FREE, 16'hFFFF);
      send_request(REQ_FREE, 16'hFFE0);
      send_request(REQ_FREE, 16'h2000);
      send_request(REQ_FREE, 16'h1FE0);
      send_request(REQ_FREE, 16'h0000);
      send_request(REQ_FREE, 16'h0000);
      send_request(REQ_ALLOC, 16'h0000);
      send_request(REQ_ALLOC, 16'hFFFF);

      // Empty pool: nothing to allocate or free.
      set_pool_size(9'd0);
      send_request(REQ_ALLOC, 16'h0000);
      send_request(REQ_FREE, 16'h0000);

      // Single block: exhaust, free, reuse.
      set_pool_size(9'd1);
      send_request(REQ_ALLOC, 16'h0000);
      send_request(REQ_ALLOC, 16'h0000);
      send_request(REQ_FREE, 16'h0000);
      send_request(REQ_ALLOC, 16'h0000);

      // Oversized count saturates; top block was never handed out.
      set_pool_size(9'h1FF);
      send_request(REQ_ALLOC, 16'h0000);
      send_request(REQ_FREE, 16'h1FE0);
      send_request(REQ_FREE, 16'h0000);

      // Random phases over several pool sizes and idle patterns.
      for (int ph = 0; ph < 8; ph++) begin
         set_pool_size(CFG_W'(pool_sizes[ph]));
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         if (ph == 4) want_hold_off <= 1'b1;
         count = (pool_sizes[ph] == 0) ? 40 : 130;
         run_random(count);
      end

      // Drain and settle.
      req_valid <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      do @(posedge clock); while (sb.pending.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
